// ===== design/single_source_shortest_path_defines.svh =====
// ----------------------------------------------------------------------------
// Shortest path engine assertion macros
// Shared wrappers for the concurrent checks of the shortest path block.
// ----------------------------------------------------------------------------
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// Generic clocked check, disabled while the active-low reset is asserted
`define SSP_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check on the block clock and reset
`define SSP_ASSERT(label, prop, msg) `SSP_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== design/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest path package
// Field widths, stored word layouts and register map of the shortest path block.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int FIELD_NODE_W = 4;
    localparam int COST_W       = 16;
    localparam int DIST_W       = 20;
    localparam int CFG_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    // Bit 20 set in a stored distance means the node has not been reached
    localparam logic [DIST_W:0]   INF_MARK = {1'b1, {DIST_W{1'b0}}};
    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    // Register index, taken from paddr[2]
    localparam logic REG_SOURCE_NODE = 1'b0;

    typedef struct packed {
        logic [FIELD_NODE_W-1:0] from_node;
        logic [FIELD_NODE_W-1:0] to_node;
        logic [COST_W-1:0]       cost;
    } edge_t;

    typedef struct packed {
        logic                    done;
        logic [DIST_W:0]         path_dist;
        logic [FIELD_NODE_W-1:0] parent;
    } node_t;

endpackage

// ===== design/ssp_ram.sv =====
// ----------------------------------------------------------------------------
// Shortest path RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ssp_engine.sv =====
// ----------------------------------------------------------------------------
// Shortest path engine
// Edge loading, node table init, min-distance scan, edge relaxation and
// result readout, all by reads and writes on the edge and node RAMs.
// ----------------------------------------------------------------------------
`include "single_source_shortest_path_defines.svh"

module ssp_engine #(
    parameter int NODE_COUNT    = 16,
    parameter int EDGE_CAPACITY = 64,
    parameter int NODE_W        = $clog2(NODE_COUNT),
    parameter int EA_W          = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [ssp_pkg::FIELD_NODE_W-1:0]   source_node,
    // edge input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ssp_pkg::FIELD_NODE_W-1:0]   s_edge_from,
    input  logic [ssp_pkg::FIELD_NODE_W-1:0]   s_edge_to,
    input  logic [ssp_pkg::COST_W-1:0]         s_edge_weight,
    input  logic                               s_last_edge,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ssp_pkg::FIELD_NODE_W-1:0]   m_node_index,
    output logic [ssp_pkg::DIST_W-1:0]         m_distance,
    output logic                               m_reachable,
    output logic [ssp_pkg::FIELD_NODE_W-1:0]   m_parent_node,
    output logic                               m_edges_dropped,
    output logic                               m_last_result,
    // edge RAM
    output logic                               edge_we,
    output logic [EA_W-1:0]                    edge_waddr,
    output ssp_pkg::edge_t                     edge_wdata,
    output logic [EA_W-1:0]                    edge_raddr,
    input  ssp_pkg::edge_t                     edge_rdata,
    // node RAM
    output logic                               node_we,
    output logic [NODE_W-1:0]                  node_waddr,
    output ssp_pkg::node_t                     node_wdata,
    output logic [NODE_W-1:0]                  node_raddr,
    input  ssp_pkg::node_t                     node_rdata
);

    localparam int NC_W  = $clog2(NODE_COUNT + 1);
    localparam int EC_W  = $clog2(EDGE_CAPACITY + 1);
    localparam int CMP_W = (NODE_W > ssp_pkg::FIELD_NODE_W) ? NODE_W : ssp_pkg::FIELD_NODE_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_INIT  = 9'b000000010,
        ST_SCAN  = 9'b000000100,
        ST_PICK  = 9'b000001000,
        ST_ECHK  = 9'b000010000,
        ST_NCHK  = 9'b000100000,
        ST_ORD   = 9'b001000000,
        ST_OWAIT = 9'b010000000,
        ST_OHOLD = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NC_W-1:0]        idx_reg, idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [NODE_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                   found_reg, found_next;
    logic [NODE_W-1:0]      pick_reg, pick_next;
    ssp_pkg::node_t         pick_word_reg, pick_word_next;
    logic [EC_W-1:0]        ec_reg, ec_next;
    logic [EC_W-1:0]        ei_reg, ei_next;
    logic                   ovf_reg, ovf_next;
    logic [NODE_W-1:0]      cur_to_reg, cur_to_next;
    logic [ssp_pkg::COST_W-1:0] cur_cost_reg, cur_cost_next;

    logic                   m_valid_reg, m_valid_next;
    logic [ssp_pkg::FIELD_NODE_W-1:0] m_node_index_reg, m_node_index_next;
    logic [ssp_pkg::DIST_W-1:0]       m_distance_reg, m_distance_next;
    logic                   m_reachable_reg, m_reachable_next;
    logic [ssp_pkg::FIELD_NODE_W-1:0] m_parent_node_reg, m_parent_node_next;
    logic                   m_edges_dropped_reg, m_edges_dropped_next;
    logic                   m_last_result_reg, m_last_result_next;

    logic                   src_ok;
    logic [NODE_W-1:0]      idx_node;
    logic                   last_idx;
    logic                   issue;
    logic                   eligible;
    logic                   edge_match;
    logic [EC_W-1:0]        ei_plus;
    logic [ssp_pkg::DIST_W:0]   sum_c;
    logic [ssp_pkg::DIST_W-1:0] cand_c;
    logic                   upd;
    logic                   reach;

    logic                   last_edge_taken;
    logic                   last_taken;
    logic                   store_clean;
    logic                   pick_hit;
    logic                   pick_open;

    assign src_ok   = 32'(source_node) < NODE_COUNT;
    assign idx_node = idx_reg[NODE_W-1:0];
    assign last_idx = idx_reg == NC_W'(NODE_COUNT - 1);
    assign issue    = idx_reg < NC_W'(NODE_COUNT);
    assign ei_plus  = ei_reg + 1'b1;

    assign eligible = !node_rdata.done && !node_rdata.path_dist[ssp_pkg::DIST_W] &&
                      (!found_reg || (node_rdata.path_dist < pick_word_reg.path_dist));

    assign edge_match = (CMP_W'(edge_rdata.from_node) == CMP_W'(pick_reg)) &&
                        (32'(edge_rdata.to_node) < NODE_COUNT);

    assign sum_c  = (ssp_pkg::DIST_W + 1)'(pick_word_reg.path_dist[ssp_pkg::DIST_W-1:0]) +
                    (ssp_pkg::DIST_W + 1)'(cur_cost_reg);
    assign cand_c = sum_c[ssp_pkg::DIST_W] ? ssp_pkg::DIST_SAT : sum_c[ssp_pkg::DIST_W-1:0];
    assign upd    = node_rdata.path_dist[ssp_pkg::DIST_W] ||
                    ({1'b0, cand_c} < node_rdata.path_dist);
    assign reach  = !node_rdata.path_dist[ssp_pkg::DIST_W];

    always_comb begin
        state_next           = state_reg;
        idx_next             = idx_reg;
        chk_vld_next         = chk_vld_reg;
        chk_idx_next         = chk_idx_reg;
        found_next           = found_reg;
        pick_next            = pick_reg;
        pick_word_next       = pick_word_reg;
        ec_next              = ec_reg;
        ei_next              = ei_reg;
        ovf_next             = ovf_reg;
        cur_to_next          = cur_to_reg;
        cur_cost_next        = cur_cost_reg;
        m_valid_next         = m_valid_reg;
        m_node_index_next    = m_node_index_reg;
        m_distance_next      = m_distance_reg;
        m_reachable_next     = m_reachable_reg;
        m_parent_node_next   = m_parent_node_reg;
        m_edges_dropped_next = m_edges_dropped_reg;
        m_last_result_next   = m_last_result_reg;

        s_ready    = 1'b0;
        edge_we    = 1'b0;
        edge_waddr = ec_reg[EA_W-1:0];
        edge_wdata = '{from_node: s_edge_from, to_node: s_edge_to, cost: s_edge_weight};
        edge_raddr = '0;
        node_we    = 1'b0;
        node_waddr = idx_node;
        node_wdata = '0;
        node_raddr = '0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (ec_reg < EC_W'(EDGE_CAPACITY)) begin
                        edge_we = 1'b1;
                        ec_next = ec_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last_edge) begin
                        idx_next   = '0;
                        state_next = ST_INIT;
                    end
                end
            end

            ST_INIT: begin
                node_we = 1'b1;
                if (src_ok && (CMP_W'(source_node) == CMP_W'(idx_node))) begin
                    node_wdata = '{done: 1'b0, path_dist: '0, parent: source_node};
                end else begin
                    node_wdata = '{done: 1'b0, path_dist: ssp_pkg::INF_MARK, parent: '0};
                end
                if (last_idx) begin
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                    found_next   = 1'b0;
                    state_next   = ST_SCAN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Stream node reads; judge each one in the cycle after its read
            ST_SCAN: begin
                chk_vld_next = issue;
                chk_idx_next = idx_node;
                if (issue) begin
                    node_raddr = idx_node;
                    idx_next   = idx_reg + 1'b1;
                end
                if (chk_vld_reg && eligible) begin
                    found_next     = 1'b1;
                    pick_next      = chk_idx_reg;
                    pick_word_next = node_rdata;
                end
                if (!issue && !chk_vld_reg) begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK: begin
                if (found_reg) begin
                    node_we    = 1'b1;
                    node_waddr = pick_reg;
                    node_wdata = '{done: 1'b1, path_dist: pick_word_reg.path_dist,
                                   parent: pick_word_reg.parent};
                    if (ec_reg != '0) begin
                        ei_next    = '0;
                        edge_raddr = '0;
                        state_next = ST_ECHK;
                    end else begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end else begin
                    idx_next   = '0;
                    state_next = ST_ORD;
                end
            end

            ST_ECHK: begin
                cur_to_next   = NODE_W'(edge_rdata.to_node);
                cur_cost_next = edge_rdata.cost;
                if (edge_match) begin
                    node_raddr = NODE_W'(edge_rdata.to_node);
                    state_next = ST_NCHK;
                end else if (ei_plus < ec_reg) begin
                    ei_next    = ei_plus;
                    edge_raddr = ei_plus[EA_W-1:0];
                end else begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            // Relax one edge; the write lands before the next node read
            ST_NCHK: begin
                if (upd) begin
                    node_we    = 1'b1;
                    node_waddr = cur_to_reg;
                    node_wdata = '{done: node_rdata.done, path_dist: {1'b0, cand_c},
                                   parent: ssp_pkg::FIELD_NODE_W'(pick_reg)};
                end
                if (ei_plus < ec_reg) begin
                    ei_next    = ei_plus;
                    edge_raddr = ei_plus[EA_W-1:0];
                    state_next = ST_ECHK;
                end else begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_ORD: begin
                node_raddr = idx_node;
                state_next = ST_OWAIT;
            end

            ST_OWAIT: begin
                m_valid_next         = 1'b1;
                m_node_index_next    = ssp_pkg::FIELD_NODE_W'(idx_node);
                m_distance_next      = reach ? node_rdata.path_dist[ssp_pkg::DIST_W-1:0] : '0;
                m_reachable_next     = reach;
                m_parent_node_next   = reach ? node_rdata.parent : '0;
                m_edges_dropped_next = ovf_reg;
                m_last_result_next   = last_idx;
                state_next           = ST_OHOLD;
            end

            ST_OHOLD: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (last_idx) begin
                        ec_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_ORD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            ec_reg      <= '0;
            ei_reg      <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            ec_reg      <= ec_next;
            ei_reg      <= ei_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg         <= chk_idx_next;
        pick_reg            <= pick_next;
        pick_word_reg       <= pick_word_next;
        cur_to_reg          <= cur_to_next;
        cur_cost_reg        <= cur_cost_next;
        m_node_index_reg    <= m_node_index_next;
        m_distance_reg      <= m_distance_next;
        m_reachable_reg     <= m_reachable_next;
        m_parent_node_reg   <= m_parent_node_next;
        m_edges_dropped_reg <= m_edges_dropped_next;
        m_last_result_reg   <= m_last_result_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_node_index    = m_node_index_reg;
    assign m_distance      = m_distance_reg;
    assign m_reachable     = m_reachable_reg;
    assign m_parent_node   = m_parent_node_reg;
    assign m_edges_dropped = m_edges_dropped_reg;
    assign m_last_result   = m_last_result_reg;

    assign last_edge_taken = s_valid && s_ready && s_last_edge;
    assign last_taken      = m_valid && m_ready && m_last_result;
    assign store_clean     = s_ready && (ec_reg == '0) && !ovf_reg;
    assign pick_hit        = (state_reg == ST_PICK) && found_reg;
    assign pick_open       = !pick_word_reg.path_dist[ssp_pkg::DIST_W] && !pick_word_reg.done;

    `SSP_ASSERT(a_hold_in_search, last_edge_taken |=> !s_ready, "request taken during search")
    `SSP_ASSERT(a_clean_after_last, last_taken |=> store_clean, "store not emptied")
    `SSP_ASSERT(a_edge_count_bound, ec_reg <= EC_W'(EDGE_CAPACITY), "edge count overrun")
    `SSP_ASSERT(a_pick_open_finite, pick_hit |-> pick_open, "picked node done or unreached")
    `SSP_ASSERT(a_relax_range, (state_reg == ST_ECHK) |-> (ei_reg < ec_reg), "relax index overrun")

endmodule

// ===== design/single_source_shortest_path.sv =====
// ----------------------------------------------------------------------------
// Single source shortest path
// Stores directed weighted edges, runs Dijkstra from a configured source on
// the last edge, then reports distance, parent and reachability per node.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake             Payload
//   s_       in   s_valid / s_ready     edge_from, edge_to, edge_weight, last_edge
//   m_       out  m_valid / m_ready     node_index, distance, reachable,
//                                       parent_node, edges_dropped, last_result
//   apb      in   psel/penable/pready   source_node at byte address 0
//
// Edge loading takes one request per cycle while the engine is idle; the edge RAM write port sets it.
// A search runs a node table init, then per settled node a scan and pick and
// a pass over the stored edges that reads the node at the far end of each edge
// leaving that node, then a closing scan and pick; each result is then read
// through the node RAM port and held until it is taken.
// Reset is synchronous, active low; it empties the edge store and clears
// the overflow flag. The input is held off from the last edge until the last
// result is taken; a stalled result holds the engine.
//
module single_source_shortest_path #(
    parameter int NODE_COUNT    = 16,
    parameter int EDGE_CAPACITY = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [ssp_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    // edge input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ssp_pkg::FIELD_NODE_W-1:0]    s_edge_from,
    input  logic [ssp_pkg::FIELD_NODE_W-1:0]    s_edge_to,
    input  logic [ssp_pkg::COST_W-1:0]          s_edge_weight,
    input  logic                                s_last_edge,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ssp_pkg::FIELD_NODE_W-1:0]    m_node_index,
    output logic [ssp_pkg::DIST_W-1:0]          m_distance,
    output logic                                m_reachable,
    output logic [ssp_pkg::FIELD_NODE_W-1:0]    m_parent_node,
    output logic                                m_edges_dropped,
    output logic                                m_last_result
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int EA_W   = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int EDGE_WORD_W = $bits(ssp_pkg::edge_t);
    localparam int NODE_WORD_W = $bits(ssp_pkg::node_t);

    logic [ssp_pkg::FIELD_NODE_W-1:0] source_node_reg, source_node_next;
    logic                             reg_hit;

    logic              edge_we;
    logic [EA_W-1:0]   edge_waddr;
    ssp_pkg::edge_t    edge_wdata;
    logic [EA_W-1:0]   edge_raddr;
    ssp_pkg::edge_t    edge_rdata;
    logic [EDGE_WORD_W-1:0] edge_rword;

    logic              node_we;
    logic [NODE_W-1:0] node_waddr;
    ssp_pkg::node_t    node_wdata;
    logic [NODE_W-1:0] node_raddr;
    ssp_pkg::node_t    node_rdata;
    logic [NODE_WORD_W-1:0] node_rword;

    // Register index sits at paddr[2]; low bits are the byte offset
    assign reg_hit = paddr[2] == ssp_pkg::REG_SOURCE_NODE;
    assign pready  = 1'b1;

    always_comb begin
        source_node_next = source_node_reg;
        if (psel && penable && pwrite && reg_hit) begin
            source_node_next = pwdata[ssp_pkg::FIELD_NODE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_node_reg <= '0;
        end else begin
            source_node_reg <= source_node_next;
        end
    end

    assign prdata = reg_hit ? ssp_pkg::CFG_DATA_W'(source_node_reg) : '0;

    assign edge_rdata = ssp_pkg::edge_t'(edge_rword);
    assign node_rdata = ssp_pkg::node_t'(node_rword);

    ssp_ram #(
        .WIDTH  (EDGE_WORD_W),
        .DEPTH  (EDGE_CAPACITY),
        .ADDR_W (EA_W)
    ) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rword)
    );

    ssp_ram #(
        .WIDTH  (NODE_WORD_W),
        .DEPTH  (NODE_COUNT),
        .ADDR_W (NODE_W)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rword)
    );

    ssp_engine #(
        .NODE_COUNT    (NODE_COUNT),
        .EDGE_CAPACITY (EDGE_CAPACITY),
        .NODE_W        (NODE_W),
        .EA_W          (EA_W)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .source_node     (source_node_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_edge_from     (s_edge_from),
        .s_edge_to       (s_edge_to),
        .s_edge_weight   (s_edge_weight),
        .s_last_edge     (s_last_edge),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_node_index    (m_node_index),
        .m_distance      (m_distance),
        .m_reachable     (m_reachable),
        .m_parent_node   (m_parent_node),
        .m_edges_dropped (m_edges_dropped),
        .m_last_result   (m_last_result),
        .edge_we         (edge_we),
        .edge_waddr      (edge_waddr),
        .edge_wdata      (edge_wdata),
        .edge_raddr      (edge_raddr),
        .edge_rdata      (edge_rdata),
        .node_we         (node_we),
        .node_waddr      (node_waddr),
        .node_wdata      (node_wdata),
        .node_raddr      (node_raddr),
        .node_rdata      (node_rdata)
    );

endmodule

// ===== sim/single_source_shortest_path_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest path engine testbench
// Streams directed edge graphs into the block, solves each graph in a local
// Dijkstra predictor and checks every per-node result, field by field, under
// random source and sink stalls and random source-node settings.
// ----------------------------------------------------------------------------
module single_source_shortest_path_tb;

    localparam int NODES         = 16;
    localparam int EDGE_SLOTS    = 64;
    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 50;
    localparam int TIMEOUT_NS    = 2_000_000;

    localparam logic [ssp_pkg::APB_ADDR_W-1:0] ADDR_SOURCE   = {ssp_pkg::REG_SOURCE_NODE, 2'b00};
    localparam logic [ssp_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = {~ssp_pkg::REG_SOURCE_NODE, 2'b00};

    typedef struct packed {
        logic [ssp_pkg::FIELD_NODE_W-1:0] node;
        logic [ssp_pkg::DIST_W-1:0]       path_dist;
        logic                             reach;
        logic [ssp_pkg::FIELD_NODE_W-1:0] parent;
        logic                             dropped;
        logic                             last;
    } node_report_t;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [ssp_pkg::APB_ADDR_W-1:0]      paddr;
    logic [ssp_pkg::CFG_DATA_W-1:0]      pwdata;
    logic [ssp_pkg::CFG_DATA_W-1:0]      prdata;
    logic                                pready;
    logic                                s_valid;
    logic                                s_ready;
    logic [ssp_pkg::FIELD_NODE_W-1:0]    s_edge_from;
    logic [ssp_pkg::FIELD_NODE_W-1:0]    s_edge_to;
    logic [ssp_pkg::COST_W-1:0]          s_edge_weight;
    logic                                s_last_edge;
    logic                                m_valid;
    logic                                m_ready;
    logic [ssp_pkg::FIELD_NODE_W-1:0]    m_node_index;
    logic [ssp_pkg::DIST_W-1:0]          m_distance;
    logic                                m_reachable;
    logic [ssp_pkg::FIELD_NODE_W-1:0]    m_parent_node;
    logic                                m_edges_dropped;
    logic                                m_last_result;

    // predictor state
    logic [ssp_pkg::FIELD_NODE_W-1:0]    src_node;
    ssp_pkg::edge_t                      edge_store[$];
    logic                                store_dropped;
    node_report_t                        node_reports_q[$];
    node_report_t                        report_seen;

    int error_count;
    int graphs_solved;
    int edges_accepted;
    int reports_checked;
    int overflow_graphs;
    int send_idle_pct;
    int recv_idle_pct;

    single_source_shortest_path #(
        .NODE_COUNT    (NODES),
        .EDGE_CAPACITY (EDGE_SLOTS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_edge_from     (s_edge_from),
        .s_edge_to       (s_edge_to),
        .s_edge_weight   (s_edge_weight),
        .s_last_edge     (s_last_edge),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_node_index    (m_node_index),
        .m_distance      (m_distance),
        .m_reachable     (m_reachable),
        .m_parent_node   (m_parent_node),
        .m_edges_dropped (m_edges_dropped),
        .m_last_result   (m_last_result)
    );

    always begin
        #(CLK_HALF_NS) aclk = 1'b1;
        #(CLK_HALF_NS) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Dijkstra over the stored edges; queue one report per node
    function automatic void solve_paths();
        logic [ssp_pkg::DIST_W:0]         path_dist [NODES];
        logic [ssp_pkg::FIELD_NODE_W-1:0] par [NODES];
        bit                               settled [NODES];
        logic [ssp_pkg::DIST_W+1:0]       cand;
        node_report_t                     rep;
        int                               pick;
        int                               dst;
        bit                               found;
        for (int n = 0; n < NODES; n++) begin
            path_dist[n] = ssp_pkg::INF_MARK;
            par[n]       = '0;
            settled[n]   = 1'b0;
        end
        path_dist[src_node] = '0;
        par[src_node]       = src_node;
        do begin
            found = 1'b0;
            pick  = 0;
            for (int n = 0; n < NODES; n++) begin
                if (!settled[n] && path_dist[n] != ssp_pkg::INF_MARK &&
                        (!found || path_dist[n] < path_dist[pick])) begin
                    pick  = n;
                    found = 1'b1;
                end
            end
            if (found) begin
                settled[pick] = 1'b1;
                foreach (edge_store[e]) begin
                    if (edge_store[e].from_node == pick) begin
                        dst  = edge_store[e].to_node;
                        cand = (ssp_pkg::DIST_W + 2)'(path_dist[pick]) +
                               (ssp_pkg::DIST_W + 2)'(edge_store[e].cost);
                        if (cand > ssp_pkg::DIST_SAT)
                            cand = {2'b00, ssp_pkg::DIST_SAT};
                        if (path_dist[dst] == ssp_pkg::INF_MARK || cand < path_dist[dst]) begin
                            path_dist[dst] = cand[ssp_pkg::DIST_W:0];
                            par[dst]       = ssp_pkg::FIELD_NODE_W'(pick);
                        end
                    end
                end
            end
        end while (found);
        for (int n = 0; n < NODES; n++) begin
            rep.node      = ssp_pkg::FIELD_NODE_W'(n);
            rep.reach     = (path_dist[n] != ssp_pkg::INF_MARK);
            rep.path_dist = rep.reach ? path_dist[n][ssp_pkg::DIST_W-1:0] : '0;
            rep.parent    = rep.reach ? par[n] : '0;
            rep.dropped   = store_dropped;
            rep.last      = (n == NODES - 1);
            node_reports_q.insert(node_reports_q.size(), rep);
        end
    endfunction

    function automatic void take_edge(input logic [3:0] from_n, input logic [3:0] to_n,
                                      input logic [15:0] weight, input logic last);
        ssp_pkg::edge_t ed;
        ed.from_node = from_n;
        ed.to_node   = to_n;
        ed.cost      = weight;
        edges_accepted++;
        if (edge_store.size() < EDGE_SLOTS)
            edge_store.insert(edge_store.size(), ed);
        else
            store_dropped = 1'b1;
        if (last) begin
            solve_paths();
            graphs_solved++;
            if (store_dropped)
                overflow_graphs++;
            edge_store.delete();
            store_dropped = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (node_reports_q.size() == 0) begin
                $error("node_index: expected no result, got %0d", m_node_index);
                error_count++;
            end else begin
                report_seen = node_reports_q.pop_front();
                reports_checked++;
                check_field("node_index", report_seen.node, m_node_index);
                check_field("distance", report_seen.path_dist, m_distance);
                check_field("reachable", report_seen.reach, m_reachable);
                check_field("parent_node", report_seen.parent, m_parent_node);
                check_field("edges_dropped", report_seen.dropped, m_edges_dropped);
                check_field("last_result", report_seen.last, m_last_result);
            end
        end
    end

    task automatic send_edge(input logic [3:0] from_n, input logic [3:0] to_n,
                             input logic [15:0] weight, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_edge_from   <= from_n;
        s_edge_to     <= to_n;
        s_edge_weight <= weight;
        s_last_edge   <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        take_edge(from_n, to_n, weight, last);
    endtask

    // Drop valid, wait out every pending result, then let the engine settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (node_reports_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [ssp_pkg::APB_ADDR_W-1:0] addr,
                             input logic [ssp_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[2] == ssp_pkg::REG_SOURCE_NODE)
            src_node = data[ssp_pkg::FIELD_NODE_W-1:0];
    endtask

    // Grow each edge mostly from nodes already touched so paths get deep
    task automatic random_graph(input int n_edges);
        logic [3:0]  touched[$];
        logic [3:0]  from_n;
        logic [3:0]  to_n;
        logic [15:0] weight;
        touched.insert(touched.size(), src_node);
        for (int k = 0; k < n_edges; k++) begin
            if ($urandom_range(99) < 60)
                from_n = touched[$urandom_range(touched.size() - 1)];
            else
                from_n = 4'($urandom_range(NODES - 1));
            to_n = 4'($urandom_range(NODES - 1));
            case ($urandom_range(2))
                0:       weight = 16'($urandom_range(7));
                1:       weight = 16'($urandom_range(255));
                default: weight = 16'($urandom_range(16'hFFFF));
            endcase
            touched.insert(touched.size(), to_n);
            send_edge(from_n, to_n, weight, k == n_edges - 1);
        end
    endtask

    // Only the source is reachable; the lone edge never leaves it
    task automatic test_lone_edge();
        send_edge(4'd15, 4'd15, 16'hFFFF, 1'b1);
    endtask

    // A write to an unmapped address must leave the source untouched
    task automatic test_unmapped_write();
        wait_idle();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        send_edge(4'd0, 4'd3, 16'd7, 1'b1);
    endtask

    // Equal-cost routes keep the parent found first; zero weights and a back edge
    task automatic test_equal_cost_paths();
        wait_idle();
        apb_write(ADDR_SOURCE, 32'd3);
        send_edge(4'd3, 4'd5, 16'd4, 1'b0);
        send_edge(4'd3, 4'd6, 16'd4, 1'b0);
        send_edge(4'd6, 4'd9, 16'd1, 1'b0);
        send_edge(4'd5, 4'd9, 16'd1, 1'b0);
        send_edge(4'd9, 4'd3, 16'd0, 1'b0);
        send_edge(4'd6, 4'd2, 16'd0, 1'b1);
    endtask

    task automatic test_max_weight_chain();
        wait_idle();
        apb_write(ADDR_SOURCE, 32'd15);
        for (int k = NODES - 1; k >= 1; k--)
            send_edge(4'(k), 4'(k - 1), 16'hFFFF, k == 1);
    endtask

    task automatic test_random_graphs(input int snd_pct, input int rcv_pct, input int n_graphs);
        wait_idle();
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        apb_write(ADDR_SOURCE, $urandom);
        for (int g = 0; g < n_graphs; g++) begin
            if ($urandom_range(2) == 0) begin
                wait_idle();
                if ($urandom_range(3) == 0)
                    apb_write(ADDR_UNMAPPED, $urandom);
                apb_write(ADDR_SOURCE, $urandom);
            end
            random_graph($urandom_range(1, 20));
        end
    endtask

    // Fill the store exactly, then overrun it with the last edge dropped too
    task automatic test_edge_store_limits();
        wait_idle();
        random_graph(EDGE_SLOTS);
        random_graph(EDGE_SLOTS + 6);
    endtask

    initial begin
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_edge_from     = '0;
        s_edge_to       = '0;
        s_edge_weight   = '0;
        s_last_edge     = 1'b0;
        src_node        = '0;
        store_dropped   = 1'b0;
        error_count     = 0;
        graphs_solved   = 0;
        edges_accepted  = 0;
        reports_checked = 0;
        overflow_graphs = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_lone_edge();
        test_unmapped_write();
        test_equal_cost_paths();
        test_max_weight_chain();
        test_random_graphs(18, 45, 6);
        test_random_graphs(45, 18, 6);
        test_edge_store_limits();
        test_random_graphs(0, 0, 6);
        wait_idle();

        $display("Solved %0d graphs from %0d edge requests; %0d node results checked.",
                 graphs_solved, edges_accepted, reports_checked);
        $display("%0d graphs overran the edge store; source node swept across its range.",
                 overflow_graphs);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
